@@ hw/rtl/gradient_orientation_cell_histogram_top_defines.svh @@
// Assertion macros for the gradient orientation cell histogram.
// Used by gradient_orientation_cell_histogram_top; no other dependencies.
`ifndef GRADIENT_ORIENTATION_CELL_HISTOGRAM_TOP_DEFINES_SVH
`define GRADIENT_ORIENTATION_CELL_HISTOGRAM_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define GOCH_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("implication check failed");
`define GOCH_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("next-cycle check failed");
`else
`define GOCH_ASSERT_IMP(lbl, a, c)
`define GOCH_ASSERT_NEXT(lbl, a, c)
`endif
`endif

@@ hw/rtl/goch_pkg.sv @@
// Package for the gradient orientation cell histogram: sizes, types, tangent table.
// No dependencies.
`timescale 1ns / 1ps
package goch_pkg;
	localparam int WIN_WIDTH  = 64;
	localparam int WIN_HEIGHT = 128;
	localparam int CELL_SIZE  = 8;
	localparam int NBINS      = 9;
	localparam int CELLS_X    = WIN_WIDTH / CELL_SIZE;
	localparam int CELLS_Y    = WIN_HEIGHT / CELL_SIZE;
	localparam int COL_W      = $clog2(WIN_WIDTH);
	localparam int ROW_W      = $clog2(WIN_HEIGHT);
	localparam int CX_W       = 3;
	localparam int CY_W       = 4;
	localparam int BIN_W      = 4;
	localparam int SUM_W      = 21;
	localparam int MAG_W      = 15;
	localparam int SQ_W       = 22;
	localparam int RAD_W      = 30;
	localparam int DEPTH      = CELLS_X * NBINS;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int FIFO_DEPTH = 2;

	typedef logic signed [33:0] tan_t;
	localparam tan_t TAN_Q30 [8] = '{
		-34'sd2950081416, -34'sd1279635676, -34'sd619925131, -34'sd189329654,
		34'sd189329654, 34'sd619925131, 34'sd1279635676, 34'sd2950081416
	};

	typedef struct packed {
		logic              clear;
		logic              upd;
		logic              emit;
		logic [CX_W-1:0]   cx;
		logic [CY_W-1:0]   cy;
		logic [BIN_W-1:0]  bin;
		logic [MAG_W-1:0]  mag;
	} goch_item_t;

	typedef enum logic [1:0] {F_IDLE, F_SQRT, F_PUSH} front_state_t;
	typedef enum logic [2:0] {B_IDLE, B_UPD, B_ERD, B_EOUT} back_state_t;
endpackage

@@ hw/rtl/goch_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module goch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ hw/rtl/goch_fifo.sv @@
// Short queue of classified pixels between front and back.
// Depends on goch_pkg.
`timescale 1ns / 1ps
module goch_fifo import goch_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  goch_item_t wr_item,
	output logic       full,
	input  logic       pop,
	output goch_item_t rd_item,
	output logic       empty
);
	goch_item_t   slot_q [FIFO_DEPTH];
	logic         wptr_q, rptr_q;
	logic [1:0]   cnt_q;

	assign full    = (cnt_q == 2'(FIFO_DEPTH));
	assign empty   = (cnt_q == 2'd0);
	assign rd_item = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop)  rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

@@ hw/rtl/goch_front.sv @@
// Front end: accepts pixels, tracks position, picks bin, iterative square root.
// Depends on goch_pkg.
`timescale 1ns / 1ps
module goch_front import goch_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [10:0]      grad_x,
	input  logic signed [10:0]      grad_y,
	input  logic                    window_start,
	input  logic                    in_valid,
	output logic                    in_ready,
	output logic                    push,
	output goch_item_t              item,
	input  logic                    full
);
	front_state_t       state_q, state_d;
	logic [COL_W-1:0]   col_q, col_cur;
	logic [ROW_W-1:0]   row_q, row_cur;
	logic [3:0]         step_q;
	logic [RAD_W-1:0]   rad_q;
	logic [17:0]        rem_q;
	logic [MAG_W-1:0]   root_q;
	goch_item_t         item_q;
	logic               acc;
	logic [BIN_W-1:0]   bin_c;
	logic signed [21:0] sqx, sqy;
	logic [SQ_W-1:0]    sq_sum;
	logic [19:0]        rem_sh, trial;
	logic               in_range, last_px;

	assign acc = in_valid && in_ready;

	always_comb begin
		logic signed [45:0] lhs, rhs;
		bin_c = '0;
		lhs   = 46'(grad_y) <<< 30;
		for (int k = 0; k < 8; k++) begin
			rhs = 46'(TAN_Q30[k]) * 46'(grad_x);
			if (grad_x > 0 ? (lhs > rhs) : (lhs < rhs)) bin_c = bin_c + 1'b1;
		end
		if (grad_x == 0) begin
			if (grad_y > 0)      bin_c = BIN_W'(8);
			else if (grad_y < 0) bin_c = '0;
			else                 bin_c = BIN_W'(4);
		end
	end

	assign sqx    = grad_x * grad_x;
	assign sqy    = grad_y * grad_y;
	assign sq_sum = SQ_W'(sqx) + SQ_W'(sqy);

	assign col_cur  = window_start ? '0 : col_q;
	assign row_cur  = window_start ? '0 : row_q;
	assign in_range = (32'(col_cur) < CELLS_X * CELL_SIZE) &&
		(32'(row_cur) < CELLS_Y * CELL_SIZE);
	assign last_px  = (32'(col_cur) % CELL_SIZE == CELL_SIZE - 1) &&
		(32'(row_cur) % CELL_SIZE == CELL_SIZE - 1);

	assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = 20'({root_q, 2'b01});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: if (acc) state_d = F_SQRT;
			F_SQRT: if (step_q == 4'd0) state_d = F_PUSH;
			F_PUSH: if (!full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == F_IDLE);
		push     = (state_q == F_PUSH) && !full;
		item     = item_q;
		item.mag = root_q;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rad_q       <= {sq_sum, 8'd0};
			rem_q       <= '0;
			root_q      <= '0;
			item_q.clear <= window_start;
			item_q.upd  <= in_range;
			item_q.emit <= in_range && last_px;
			item_q.cx   <= CX_W'(32'(col_cur) / CELL_SIZE);
			item_q.cy   <= CY_W'(32'(row_cur) / CELL_SIZE);
			item_q.bin  <= bin_c;
			item_q.mag  <= '0;
		end else if (state_q == F_SQRT) begin
			rad_q <= rad_q << 2;
			if (rem_sh >= trial) begin
				rem_q  <= 18'(rem_sh - trial);
				root_q <= {root_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q  <= 18'(rem_sh);
				root_q <= {root_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				step_q <= 4'(MAG_W - 1);
				if (32'(col_cur) == WIN_WIDTH - 1) begin
					col_q <= '0;
					row_q <= (32'(row_cur) == WIN_HEIGHT - 1) ? '0 : row_cur + 1'b1;
				end else begin
					col_q <= col_cur + 1'b1;
					row_q <= row_cur;
				end
			end else if (state_q == F_SQRT) begin
				step_q <= step_q - 1'b1;
			end
		end
	end
endmodule

@@ hw/rtl/goch_back.sv @@
// Back end: accumulates magnitudes into per-column bin sums and emits finished cells.
// Depends on goch_pkg and goch_ram.
`timescale 1ns / 1ps
module goch_back import goch_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  goch_item_t       rd_item,
	output logic             pop,
	output logic [CX_W-1:0]  cell_col,
	output logic [CY_W-1:0]  cell_row,
	output logic [BIN_W-1:0] bin_index,
	output logic [SUM_W-1:0] bin_sum,
	output logic             cell_done,
	output logic             out_valid,
	input  logic             out_ready
);
	back_state_t       state_q, state_d;
	goch_item_t        cur_q;
	logic [BIN_W-1:0]  k_q;
	logic [DEPTH-1:0]  vld_q;
	logic [ADDR_W-1:0] base, addr_q, raddr;
	logic              re, we;
	logic [SUM_W-1:0]  rdata, old_sum, new_sum;
	logic [SUM_W:0]    add;

	assign base = ADDR_W'(cur_q.cx) * ADDR_W'(NBINS);
	assign old_sum = vld_q[addr_q] ? rdata : '0;
	assign add     = {1'b0, old_sum} + (SUM_W+1)'(cur_q.mag);
	assign new_sum = add[SUM_W] ? '1 : add[SUM_W-1:0];

	goch_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_sums (
		.clk  (clk),
		.we   (we),
		.waddr(addr_q),
		.wdata(new_sum),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (!empty && rd_item.upd) state_d = B_UPD;
			B_UPD:  state_d = cur_q.emit ? B_ERD : B_IDLE;
			B_ERD:  state_d = B_EOUT;
			B_EOUT: if (out_ready) state_d = (k_q == BIN_W'(NBINS - 1)) ? B_IDLE : B_ERD;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop   = (state_q == B_IDLE) && !empty;
		we    = (state_q == B_UPD);
		re    = pop || (state_q == B_ERD);
		raddr = (state_q == B_ERD) ? base + ADDR_W'(k_q) :
			ADDR_W'(rd_item.cx) * ADDR_W'(NBINS) + ADDR_W'(rd_item.bin);
		out_valid = (state_q == B_EOUT);
		cell_col  = cur_q.cx;
		cell_row  = cur_q.cy;
		bin_index = k_q;
		bin_sum   = old_sum;
		cell_done = (k_q == BIN_W'(NBINS - 1));
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= rd_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			vld_q   <= '0;
			k_q     <= '0;
			addr_q  <= '0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				if (rd_item.clear) vld_q <= '0;
				addr_q <= raddr;
			end
			if (we) begin
				vld_q[addr_q] <= 1'b1;
				k_q <= '0;
			end
			if (state_q == B_ERD) addr_q <= raddr;
			if (out_valid && out_ready) begin
				vld_q[addr_q] <= 1'b0;
				k_q <= k_q + 1'b1;
			end
		end
	end
endmodule

@@ hw/rtl/gradient_orientation_cell_histogram_top.sv @@
// Each pixel is accepted, takes 15 square-root steps in the front end and is then pushed to
// the queue; the front end takes no new pixel until that push, which stalls on a full queue.
// A cell's last pixel updates its bin sum in the back end, which then emits the cell's 9
// results with a gap in out_valid between them; the queue holds pixels sent meanwhile.
// Reset (arst_n, async low) clears position, queue, state and all bin-sum valid bits.
// Top level: front end, queue, back end. Depends on goch_pkg and the defines header.
`timescale 1ns / 1ps
`include "gradient_orientation_cell_histogram_top_defines.svh"
module gradient_orientation_cell_histogram_top import goch_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [10:0] grad_x,
	input  logic signed [10:0] grad_y,
	input  logic               window_start,
	input  logic               in_valid,
	output logic               in_ready,
	output logic [CX_W-1:0]    cell_col,
	output logic [CY_W-1:0]    cell_row,
	output logic [BIN_W-1:0]   bin_index,
	output logic [SUM_W-1:0]   bin_sum,
	output logic               cell_done,
	output logic               out_valid,
	input  logic               out_ready
);
	goch_item_t wr_item, rd_item;
	logic       push, full, pop, empty;

	goch_front u_front (
		.clk(clk), .arst_n(arst_n), .grad_x(grad_x), .grad_y(grad_y),
		.window_start(window_start), .in_valid(in_valid), .in_ready(in_ready),
		.push(push), .item(wr_item), .full(full)
	);

	goch_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wr_item(wr_item), .full(full),
		.pop(pop), .rd_item(rd_item), .empty(empty)
	);

	goch_back u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .rd_item(rd_item), .pop(pop),
		.cell_col(cell_col), .cell_row(cell_row), .bin_index(bin_index),
		.bin_sum(bin_sum), .cell_done(cell_done), .out_valid(out_valid),
		.out_ready(out_ready)
	);

	`GOCH_ASSERT_IMP(a_done_last, out_valid && cell_done, bin_index == BIN_W'(NBINS - 1))
	`GOCH_ASSERT_NEXT(a_gap, out_valid && out_ready && !cell_done, !out_valid)
	`GOCH_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready)
endmodule

@@ bench/tb.sv @@
// Self-checking bench for gradient_orientation_cell_histogram_top: random and directed
// gradient pixels, bursty sender, stalling receiver, scoreboard class with own predictor.
// Depends on goch_pkg and the RTL top level.
`timescale 1ns / 1ps
module tb import goch_pkg::*; ();

	typedef struct packed {
		logic [CX_W-1:0]  col;
		logic [CY_W-1:0]  row;
		logic [BIN_W-1:0] bin;
		logic [SUM_W-1:0] sum;
		logic             done;
	} cell_bin_t;

	class hist_scoreboard;
		int unsigned col_pos, row_pos;
		logic [SUM_W-1:0] sums [DEPTH];
		cell_bin_t pending [$];
		int errors;

		function new();
			col_pos = 0;
			row_pos = 0;
			errors = 0;
			foreach (sums[i]) sums[i] = '0;
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function int orient_bin(longint gx, longint gy);
			int b;
			longint lhs, rhs;
			if (gx == 0) begin
				if (gy > 0) return 8;
				if (gy < 0) return 0;
				return 4;
			end
			b = 0;
			for (int k = 0; k < 8; k++) begin
				lhs = gy * 64'sd1073741824;
				rhs = longint'(TAN_Q30[k]) * gx;
				if (gx > 0 ? (lhs > rhs) : (lhs < rhs)) b++;
			end
			return b;
		endfunction

		function void note_pixel(logic signed [10:0] gx, logic signed [10:0] gy, logic ws);
			longint sx, sy;
			longint unsigned mag, s;
			int bin, cx, cy;
			cell_bin_t r;
			sx = gx;
			sy = gy;
			if (ws) begin
				col_pos = 0;
				row_pos = 0;
				foreach (sums[i]) sums[i] = '0;
			end
			mag = int_sqrt(longint'(32'(sx * sx + sy * sy)) << 8);
			bin = orient_bin(sx, sy);
			if (col_pos < CELLS_X * CELL_SIZE && row_pos < CELLS_Y * CELL_SIZE) begin
				cx = col_pos / CELL_SIZE;
				cy = row_pos / CELL_SIZE;
				s = sums[cx * NBINS + bin] + mag;
				sums[cx * NBINS + bin] = (s > 64'h1FFFFF) ? '1 : s[SUM_W-1:0];
				if (col_pos % CELL_SIZE == CELL_SIZE - 1 &&
						row_pos % CELL_SIZE == CELL_SIZE - 1) begin
					for (int k = 0; k < NBINS; k++) begin
						r.col = cx[CX_W-1:0];
						r.row = cy[CY_W-1:0];
						r.bin = k[BIN_W-1:0];
						r.sum = sums[cx * NBINS + k];
						r.done = (k == NBINS - 1);
						pending.insert(pending.size(), r);
						sums[cx * NBINS + k] = '0;
					end
				end
			end
			col_pos++;
			if (col_pos >= WIN_WIDTH) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= WIN_HEIGHT) row_pos = 0;
			end
		endfunction

		function void check_bin(cell_bin_t got);
			cell_bin_t e;
			if (pending.size() == 0) begin
				$error("unexpected result col=%0d row=%0d bin=%0d", got.col, got.row, got.bin);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.col !== e.col) begin
				$error("cell_col exp %0d got %0d", e.col, got.col); errors++;
			end
			if (got.row !== e.row) begin
				$error("cell_row exp %0d got %0d", e.row, got.row); errors++;
			end
			if (got.bin !== e.bin) begin
				$error("bin_index exp %0d got %0d", e.bin, got.bin); errors++;
			end
			if (got.sum !== e.sum) begin
				$error("bin_sum exp %0d got %0d", e.sum, got.sum); errors++;
			end
			if (got.done !== e.done) begin
				$error("cell_done exp %0d got %0d", e.done, got.done); errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic signed [10:0] grad_x = '0, grad_y = '0;
	logic window_start = 0, in_valid = 0, out_ready = 0;
	logic in_ready, cell_done, out_valid;
	logic [CX_W-1:0] cell_col;
	logic [CY_W-1:0] cell_row;
	logic [BIN_W-1:0] bin_index;
	logic [SUM_W-1:0] bin_sum;
	logic long_hold = 0;
	hist_scoreboard sb = new();

	gradient_orientation_cell_histogram_top u_top (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) sb.note_pixel(grad_x, grad_y, window_start);
		if (arst_n && out_valid && out_ready)
			sb.check_bin({cell_col, cell_row, bin_index, bin_sum, cell_done});
	end

	// receiver stall pattern, plus one long hold-off
	initial begin
		int mode;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 0;
				repeat (600) @(negedge clk);
				long_hold = 0;
			end
			mode = int'(($time / 20000) % 3);
			out_ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 3) != 0 || mode == 2 ?
				($urandom_range(0, 1) == 1) : 1'b0);
		end
	end

	task automatic send_pixel(logic signed [10:0] gx, logic signed [10:0] gy, logic ws);
		grad_x <= gx;
		grad_y <= gy;
		window_start <= ws;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle_gap();
		in_valid <= 0;
		repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	function automatic logic signed [10:0] rand_grad();
		case ($urandom_range(0, 5))
			0: return 11'sh400;
			1: return 11'sh3FF;
			2: return 11'sd0;
			default: return 11'($urandom);
		endcase
	endfunction

	// eight more pixels along the current line, all of one kind
	task automatic send_cell(int kind);
		logic signed [10:0] gx, gy;
		for (int i = 0; i < 8; i++) begin
			case (kind)
				0: begin gx = 11'sh400; gy = 11'sh400; end
				1: begin
					gx = 11'sd0;
					gy = (i % 3 == 0) ? 11'sd5 : (i % 3 == 1) ? -11'sd5 : 11'sd0;
				end
				default: begin gx = rand_grad(); gy = rand_grad(); end
			endcase
			send_pixel(gx, gy, 1'b0);
			if ($urandom_range(0, 4) == 0) idle_gap();
		end
	endtask

	initial begin
		int n;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed: extremes and zero gx cases
		send_pixel(11'sh400, 11'sh400, 1'b1);
		send_pixel(11'sh3FF, -11'sd1020, 1'b0);
		send_pixel(11'sd0, 11'sd0, 1'b0);
		send_pixel(11'sd0, 11'sd7, 1'b0);
		send_pixel(11'sd0, -11'sd7, 1'b0);
		for (int k = 0; k < 8; k++) send_pixel(11'sd100, 11'(-300 + 80 * k), 1'b0);
		send_pixel(-11'sd100, 11'sd50, 1'b0);
		send_pixel(-11'sd1, 11'sh3FF, 1'b0);
		// rest of line 0, then full rows until a cell row closes several cells;
		// the long receiver hold starts right after the first cell closes
		n = 15;
		while (n < 64 * 8) begin
			send_pixel(rand_grad(), rand_grad(), 1'b0);
			n++;
			if (n == 64 * 7 + 8) long_hold = 1;
			if ($urandom_range(0, 9) == 0) idle_gap();
		end
		drain();
		repeat (200) @(negedge clk);
		// short windows restarted by window_start before any cell completes
		for (int w = 0; w < 14; w++) begin
			send_pixel(rand_grad(), rand_grad(), 1'b1);
			for (int j = 0; j < 6; j++) begin
				send_pixel(rand_grad(), rand_grad(), 1'b0);
				if ($urandom_range(0, 3) == 0) idle_gap();
			end
			if (w % 4 == 3) send_cell(w % 2);
			if (w % 5 == 0) begin
				drain();
				@(negedge clk);
			end
		end
		drain();
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
